[src/rpn_checked_integer_evaluator_defines.svh]
// assertion macros for the rpn evaluator
// no dependencies
`ifndef RPN_CHECKED_INTEGER_EVALUATOR_DEFINES_SVH
`define RPN_CHECKED_INTEGER_EVALUATOR_DEFINES_SVH
`define RPN_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define RPN_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`endif

[src/rpn_pkg.sv]
// types and constants for the rpn evaluator
// no dependencies
package rpn_pkg;
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;
   typedef struct packed {
      logic signed [63:0] result_value;
      logic [1:0]         status;
   } rsp_type;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_STAR = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [63:0] INT_MAX_U = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   // token kinds sent from front to back
   localparam logic [2:0] TK_NUM = 3'd0;
   localparam logic [2:0] TK_ERR = 3'd1;
   localparam logic [2:0] TK_ADD = 3'd2;
   localparam logic [2:0] TK_SUB = 3'd3;
   localparam logic [2:0] TK_MUL = 3'd4;
   localparam logic [2:0] TK_DIV = 3'd5;
   localparam logic [2:0] TK_END = 3'd6;
   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] value;
      logic [1:0]  err;
   } tok_type;
endpackage

[src/rpn_ram.sv]
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module rpn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[src/rpn_front.sv]
// front end: scans characters into tokens
// depends on rpn_pkg
module rpn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rpn_pkg::req_type  in_item,
   output logic              in_ready,
   output logic              tok_valid,
   output rpn_pkg::tok_type  tok,
   input  logic              tok_ready
);
   import rpn_pkg::*;
   logic [63:0] mag_ff, mag_in;
   logic [1:0]  len_ff, len_in;
   logic [7:0]  first_ff, first_in;
   logic        neg_ff, neg_in;
   logic [1:0]  err_ff, err_in;
   logic        pend_ff, pend_in;
   logic        tv_ff, tv_in;
   tok_type     t_ff, t_in;
   logic        fin_has;
   logic [63:0] limit;
   logic [67:0] step;
   logic [3:0]  d;
   logic        isdig, accept, do_fin;
   logic [7:0]  c;

   // end token is queued after the last token finishes
   assign in_ready = !pend_ff && (!tv_ff || tok_ready);
   assign accept = in_valid && in_ready;
   assign tok_valid = tv_ff;
   assign tok = t_ff;
   assign c = in_item.ch;
   assign d = c[3:0] - CH_ZERO[3:0];
   assign isdig = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
   assign limit = INT_MAX_U + {63'd0, neg_ff};
   // ten times the magnitude plus the digit, wide enough to compare with the limit
   assign step = {1'b0, mag_ff, 3'd0} + {3'd0, mag_ff, 1'b0} + {64'd0, d};

   always_comb begin
      mag_in = mag_ff; len_in = len_ff; first_in = first_ff;
      neg_in = neg_ff; err_in = err_ff; pend_in = pend_ff;
      tv_in = tv_ff && !tok_ready; t_in = t_ff;
      fin_has = 1'b0;
      do_fin = accept && (c == CH_SPACE || in_item.last);
      if (pend_ff && (!tv_ff || tok_ready)) begin
         tv_in = 1'b1;
         t_in = '0;
         t_in.kind = TK_END;
         pend_in = 1'b0;
      end else if (accept) begin
         if (c != CH_SPACE) begin
            if (len_ff == 2'd0) begin
               first_in = c;
               len_in = 2'd1;
               if (c == CH_PLUS || c == CH_MINUS) neg_in = c == CH_MINUS;
               else if (isdig) begin
                  if (step > {4'd0, limit}) err_in = ST_OVERFLOW;
                  else mag_in = step[63:0];
               end else err_in = ST_INVALID;
            end else begin
               len_in = 2'd2;
               if (err_ff == ST_OK) begin
                  if (isdig) begin
                     if (step > {4'd0, limit}) err_in = ST_OVERFLOW;
                     else mag_in = step[63:0];
                  end else err_in = ST_INVALID;
               end
            end
         end
         if (do_fin) begin
            // finish with the state just updated
            fin_has = len_in != 2'd0;
            t_in.value = neg_in ? (64'd0 - mag_in) : mag_in;
            t_in.err = err_in;
            if (len_in == 2'd1 && first_in == CH_PLUS) t_in.kind = TK_ADD;
            else if (len_in == 2'd1 && first_in == CH_MINUS) t_in.kind = TK_SUB;
            else if (len_in == 2'd1 && first_in == CH_STAR) t_in.kind = TK_MUL;
            else if (len_in == 2'd1 && first_in == CH_SLASH) t_in.kind = TK_DIV;
            else if (err_in != ST_OK) t_in.kind = TK_ERR;
            else t_in.kind = TK_NUM;
            if (fin_has) tv_in = 1'b1;
            else if (in_item.last) begin
               tv_in = 1'b1;
               t_in = '0;
               t_in.kind = TK_END;
            end
            if (fin_has && in_item.last) pend_in = 1'b1;
            mag_in = '0; len_in = '0; first_in = '0; neg_in = 1'b0; err_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= '0; len_ff <= '0; first_ff <= '0; neg_ff <= 1'b0;
         err_ff <= ST_OK; pend_ff <= 1'b0; tv_ff <= 1'b0;
      end else begin
         mag_ff <= mag_in; len_ff <= len_in; first_ff <= first_in;
         neg_ff <= neg_in; err_ff <= err_in; pend_ff <= pend_in; tv_ff <= tv_in;
      end
      t_ff <= t_in;
   end
endmodule

[src/rpn_queue.sv]
// two entry token queue between front and back
// depends on rpn_pkg
module rpn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rpn_pkg::tok_type in_tok,
   output logic             in_ready,
   output logic             out_valid,
   output rpn_pkg::tok_type out_tok,
   input  logic             out_ready
);
   import rpn_pkg::*;
   tok_type    q_ff [2];
   logic [1:0] cnt_ff;
   logic       rp_ff, wp_ff;
   logic       wr, rd;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_tok = q_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rp_ff <= 1'b0; wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
      end
      if (wr) q_ff[wp_ff] <= in_tok;
   end
endmodule

[src/rpn_back.sv]
// back end: operand stack, checked arithmetic, serial multiply and divide
// depends on rpn_pkg, rpn_ram, rpn_checked_integer_evaluator_defines.svh
`include "rpn_checked_integer_evaluator_defines.svh"
module rpn_back #(
   parameter int STACK_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tok_valid,
   input  rpn_pkg::tok_type tok,
   output logic             tok_ready,
   output logic             rsp_valid,
   output rpn_pkg::rsp_type rsp_item,
   input  logic             rsp_ready
);
   import rpn_pkg::*;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD1 = 3'd1;
   localparam logic [2:0] S_RD2 = 3'd2;
   localparam logic [2:0] S_OP = 3'd3;
   localparam logic [2:0] S_ITER = 3'd4;
   localparam logic [2:0] S_WB = 3'd5;

   logic [2:0]    st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    ls_ff, ls_in;
   logic [2:0]    op_ff, op_in;
   logic [63:0]   a_ff, a_in, b_ff, b_in;
   logic [63:0]   top_ff, top_in;
   logic          neg_ff, neg_in;
   logic [127:0]  acc_ff, acc_in;
   logic [63:0]   rem_ff, rem_in;
   logic [6:0]    it_ff, it_in;
   logic [63:0]   res_ff, res_in;
   logic          ov_ff, ov_in;
   logic          ov_ok_ff, ov_ok_in;
   logic          rv_ff, rv_in;
   rsp_type       r_ff, r_in;
   logic          wen;
   logic [AW-1:0] waddr, raddr;
   logic [63:0]   wdata, rdata;
   logic [63:0]   sum, dif, ma, mb, lim;
   logic [64:0]   trial;

   rpn_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(wen), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   assign tok_ready = st_ff == S_IDLE && (!rv_ff || rsp_ready || tok.kind != TK_END);
   assign rsp_valid = rv_ff;
   assign rsp_item = r_ff;
   assign sum = a_ff + b_ff;
   assign dif = a_ff - b_ff;
   assign ma = a_ff[63] ? 64'd0 - a_ff : a_ff;
   assign mb = b_ff[63] ? 64'd0 - b_ff : b_ff;
   assign trial = {rem_ff, acc_ff[63]} - {1'b0, mb};

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; ls_in = ls_ff; op_in = op_ff;
      a_in = a_ff; b_in = b_ff; top_in = top_ff; neg_in = neg_ff;
      acc_in = acc_ff; rem_in = rem_ff; it_in = it_ff; res_in = res_ff;
      ov_in = ov_ff; ov_ok_in = ov_ok_ff;
      rv_in = rv_ff && !rsp_ready; r_in = r_ff;
      wen = 1'b0; waddr = cnt_ff[AW-1:0]; wdata = tok.value;
      // left operand address held through the S_RD1 and S_RD2 read states
      raddr = AW'(cnt_ff - CW'(2));
      lim = INT_MAX_U + {63'd0, neg_ff};
      case (st_ff)
         S_IDLE: begin
            if (tok_valid && tok_ready) begin
               if (tok.kind == TK_END) begin
                  rv_in = 1'b1;
                  r_in.status = (ls_ff == ST_OK && cnt_ff != CW'(1)) ? ST_INVALID : ls_ff;
                  r_in.result_value = top_ff;
                  if (r_in.status != ST_OK) r_in.result_value = '0;
                  cnt_in = '0; ls_in = ST_OK;
               end else if (ls_ff != ST_OK) begin
               end else if (tok.kind == TK_NUM) begin
                  if (cnt_ff >= CW'(STACK_DEPTH)) ls_in = ST_FULL;
                  else begin
                     wen = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                     top_in = tok.value;
                  end
               end else if (tok.kind == TK_ERR) ls_in = tok.err;
               else if (cnt_ff < CW'(2)) ls_in = ST_INVALID;
               else begin
                  op_in = tok.kind;
                  b_in = top_ff;
                  st_in = S_RD1;
               end
            end
         end
         S_RD1: st_in = S_RD2;
         S_RD2: begin
            a_in = rdata;
            st_in = S_OP;
         end
         S_OP: begin
            neg_in = a_ff[63] != b_ff[63];
            st_in = S_WB;
            ov_in = 1'b0;
            case (op_ff)
               TK_ADD: begin
                  res_in = sum;
                  ov_in = a_ff[63] == b_ff[63] && sum[63] != a_ff[63];
               end
               TK_SUB: begin
                  res_in = dif;
                  ov_in = a_ff[63] != b_ff[63] && dif[63] != a_ff[63];
               end
               TK_MUL: begin
                  acc_in = {64'd0, ma};
                  rem_in = '0; it_in = '0; ov_ok_in = 1'b0;
                  st_in = S_ITER;
               end
               default: begin
                  if (b_ff == 64'd0) begin
                     ls_in = ST_INVALID; st_in = S_IDLE;
                  end else if (a_ff == SIGN_BIT && b_ff == '1) begin
                     ls_in = ST_OVERFLOW; st_in = S_IDLE;
                  end else begin
                     acc_in = {64'd0, ma};
                     rem_in = '0; it_in = '0; ov_ok_in = 1'b1;
                     st_in = S_ITER;
                  end
               end
            endcase
         end
         S_ITER: begin
            it_in = it_ff + 7'd1;
            if (!ov_ok_ff) begin
               // shift and add, acc low holds multiplier bits
               if (acc_ff[0]) acc_in = {({1'b0, acc_ff[127:64]} + {1'b0, mb}), acc_ff[63:1]};
               else acc_in = {1'b0, acc_ff[127:1]};
            end else begin
               // restoring divide
               if (!trial[64]) begin
                  rem_in = trial[63:0];
                  acc_in = {64'd0, acc_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[62:0], acc_ff[63]};
                  acc_in = {64'd0, acc_ff[62:0], 1'b0};
               end
            end
            if (it_ff == 7'd63) st_in = S_WB;
         end
         S_WB: begin
            st_in = S_IDLE;
            if (op_ff == TK_MUL) begin
               ov_in = acc_ff[127:64] != 64'd0 || acc_ff[63:0] > lim;
               res_in = neg_ff ? 64'd0 - acc_ff[63:0] : acc_ff[63:0];
            end else if (op_ff == TK_DIV) begin
               res_in = neg_ff ? 64'd0 - acc_ff[63:0] : acc_ff[63:0];
            end
            if ((op_ff == TK_MUL) ?
                (acc_ff[127:64] != 64'd0 || acc_ff[63:0] > lim) : ov_ff)
               ls_in = ST_OVERFLOW;
            else begin
               wen = 1'b1;
               waddr = AW'(cnt_ff - CW'(2));
               wdata = (op_ff == TK_MUL || op_ff == TK_DIV) ?
                       (neg_ff ? 64'd0 - acc_ff[63:0] : acc_ff[63:0]) : res_ff;
               top_in = wdata;
               cnt_in = cnt_ff - CW'(1);
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_IDLE && cnt_in == CW'(1) && wen) top_in = wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; ls_ff <= ST_OK; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ls_ff <= ls_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; top_ff <= top_in;
      neg_ff <= neg_in; acc_ff <= acc_in; rem_ff <= rem_in; it_ff <= it_in;
      res_ff <= res_in; ov_ff <= ov_in; ov_ok_ff <= ov_ok_in; r_ff <= r_in;
   end

   `RPN_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CW'(STACK_DEPTH))
   `RPN_ASSERT_IMPL(a_op_needs_two, clock, reset, (st_ff == S_RD1) |-> (cnt_ff >= CW'(2)))
   `RPN_ASSERT_IMPL(a_iter_bound, clock, reset, (st_ff == S_ITER) |-> (it_ff <= 7'd63))
endmodule

[src/rpn_checked_integer_evaluator.sv]
// top level of the checked rpn integer evaluator
// depends on rpn_pkg, rpn_front, rpn_queue, rpn_back
//
// req channel: push an item (one character plus a last flag) while full is low.
// spaces split tokens; the token before a space or last is classified by the
// front end and queued to the back end. rsp channel: one item per expression,
// present while empty is low, taken with pop. status 0 ok, 1 invalid or divide
// by zero, 2 overflow, 3 stack full; value is 0 unless ok.
// in the back end a number token is handled in S_IDLE; add and
// subtract run S_RD1 and S_RD2 (registered stack read), S_OP and S_WB, and
// multiply and valid divides also S_ITER (64 step serial multiplier/divider).
// the front stalls when the two entry token queue fills, and while the end
// token is queued after a last character that ends a token.
// the end token passes the front end register and the token queue; the back
// end registers the result after the tokens queued ahead of it. a result
// waits in an output register; while it is not popped the next expression
// still streams in, and only its end token waits.
// reset clears all control state; the stack memory needs no clearing.
module rpn_checked_integer_evaluator #(
   parameter int STACK_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  rpn_pkg::req_type req_item,
   output logic             req_full,
   output logic             rsp_empty,
   output rpn_pkg::rsp_type rsp_item,
   input  logic             rsp_pop
);
   import rpn_pkg::*;
   logic    f_ready, fv, qr, qv, br, rv;
   tok_type ft, qt;
   assign req_full = !f_ready;
   assign rsp_empty = !rv;
   rpn_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_push), .in_item(req_item),
      .in_ready(f_ready), .tok_valid(fv), .tok(ft), .tok_ready(qr)
   );
   rpn_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(fv), .in_tok(ft), .in_ready(qr),
      .out_valid(qv), .out_tok(qt), .out_ready(br)
   );
   rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock(clock), .reset(reset), .tok_valid(qv), .tok(qt), .tok_ready(br),
      .rsp_valid(rv), .rsp_item(rsp_item), .rsp_ready(rsp_pop)
   );
endmodule

[tb/sv/rpn_checked_integer_evaluator_tb.sv]
// self-checking testbench for rpn_checked_integer_evaluator
// depends on rpn_pkg and the evaluator rtl; sends directed and random expressions
// one character per item and checks each result against an inline predictor
module rpn_checked_integer_evaluator_tb;
   import rpn_pkg::*;

   localparam int DEPTH = 32;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_item;
   logic    rsp_pop = 1'b0;

   rpn_checked_integer_evaluator #(.STACK_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_item(req_item), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_item(rsp_item), .rsp_pop(rsp_pop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [63:0] calc_stack [DEPTH];
   int          calc_depth;
   logic [63:0] tok_mag;
   int          tok_len;
   logic [7:0]  tok_first;
   logic        tok_neg;
   logic [1:0]  tok_err;
   logic [1:0]  calc_status;

   rsp_type expected_results [$];
   int      failures = 0;
   int      chars_sent = 0;
   int      exprs_sent = 0;
   int      results_seen = 0;
   logic    quiet = 1'b0;

   function automatic logic is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
   endfunction

   task automatic clear_token();
      tok_mag = '0;
      tok_len = 0;
      tok_first = '0;
      tok_neg = 1'b0;
      tok_err = ST_OK;
   endtask

   task automatic clear_calc();
      calc_depth = 0;
      calc_status = ST_OK;
      clear_token();
   endtask

   task automatic add_digit(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] limit;
      d = 64'(c - CH_ZERO);
      limit = INT_MAX_U + (tok_neg ? 64'd1 : 64'd0);
      if (tok_mag > (limit - d) / 64'd10) tok_err = ST_OVERFLOW;
      else tok_mag = tok_mag * 64'd10 + d;
   endtask

   task automatic take_char(logic [7:0] c);
      if (tok_len == 0) begin
         tok_first = c;
         if (c == CH_PLUS || c == CH_MINUS) tok_neg = (c == CH_MINUS);
         else if (is_digit(c)) add_digit(c);
         else tok_err = ST_INVALID;
         tok_len = 1;
      end else begin
         tok_len = 2;
         if (tok_err == ST_OK) begin
            if (is_digit(c)) add_digit(c);
            else tok_err = ST_INVALID;
         end
      end
   endtask

   function automatic logic [1:0] arith(logic [63:0] a, logic [63:0] b, logic [7:0] op,
                                        output logic [63:0] r);
      logic        neg;
      logic [63:0] ma, mb, limit;
      r = '0;
      neg = a[63] != b[63];
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      if (op == CH_PLUS) begin
         r = a + b;
         if (a[63] == b[63] && r[63] != a[63]) return ST_OVERFLOW;
      end else if (op == CH_MINUS) begin
         r = a - b;
         if (a[63] != b[63] && r[63] != a[63]) return ST_OVERFLOW;
      end else if (op == CH_STAR) begin
         limit = INT_MAX_U + (neg ? 64'd1 : 64'd0);
         if (ma == 0 || mb == 0) r = '0;
         else begin
            if (ma > limit / mb) return ST_OVERFLOW;
            r = ma * mb;
            if (neg) r = -r;
         end
      end else begin
         if (b == 0) return ST_INVALID;
         if (a == SIGN_BIT && b == '1) return ST_OVERFLOW;
         r = ma / mb;
         if (neg) r = -r;
      end
      return ST_OK;
   endfunction

   task automatic finish_token();
      logic [63:0] r;
      logic [1:0]  s;
      if (tok_len != 0) begin
         if (calc_status == ST_OK) begin
            if (tok_len == 1 && (tok_first == CH_PLUS || tok_first == CH_MINUS ||
                                 tok_first == CH_STAR || tok_first == CH_SLASH)) begin
               if (calc_depth < 2) calc_status = ST_INVALID;
               else begin
                  s = arith(calc_stack[calc_depth-2], calc_stack[calc_depth-1], tok_first, r);
                  if (s != ST_OK) calc_status = s;
                  else begin
                     calc_depth--;
                     calc_stack[calc_depth-1] = r;
                  end
               end
            end else if (tok_err != ST_OK) begin
               calc_status = tok_err;
            end else if (calc_depth >= DEPTH) begin
               calc_status = ST_FULL;
            end else begin
               calc_stack[calc_depth] = tok_neg ? -tok_mag : tok_mag;
               calc_depth++;
            end
         end
         clear_token();
      end
   endtask

   task automatic eval_char(req_type it);
      rsp_type res;
      if (it.ch == CH_SPACE) finish_token();
      else take_char(it.ch);
      if (it.last) begin
         finish_token();
         res.status = calc_status;
         if (res.status == ST_OK && calc_depth != 1) res.status = ST_INVALID;
         res.result_value = (res.status == ST_OK) ? calc_stack[0] : '0;
         expected_results.insert(expected_results.size(), res);
         clear_calc();
      end
   endtask

   task automatic send_item(req_type it);
      while (!quiet && $urandom_range(99) < 27) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      eval_char(it);
      chars_sent++;
   endtask

   task automatic send_expr(string s);
      req_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.ch = s[i];
         it.last = (i == s.len() - 1);
         send_item(it);
      end
      exprs_sent++;
   endtask

   // result checker and pop driver
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("unexpected result: value %0d status %0d",
                   rsp_item.result_value, rsp_item.status);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.result_value !== want.result_value) begin
               $error("result_value: expected %0d actual %0d",
                      want.result_value, rsp_item.result_value);
               failures++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_item.status);
               failures++;
            end
         end
      end
      rsp_pop <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
   end

   function automatic string num_text();
      string sg;
      logic [63:0] v;
      case ($urandom_range(9))
         0: sg = "-";
         1: sg = "+";
         2: sg = "-";
         default: sg = "";
      endcase
      case ($urandom_range(9))
         0, 1: v = {$urandom, $urandom};
         2: v = 64'($urandom);
         3: v = {1'b0, 31'($urandom), 32'($urandom)};
         default: v = 64'($urandom_range(0, 20));
      endcase
      return {sg, $sformatf("%0d", v)};
   endfunction

   function automatic string gen_expr();
      string s, ops;
      int depth, pushed, nnum;
      ops = "+-*/";
      s = ($urandom_range(9) == 0) ? " " : "";
      nnum = ($urandom_range(49) == 0) ? $urandom_range(31, 34) : $urandom_range(1, 6);
      depth = 0;
      pushed = 0;
      while (pushed < nnum || depth > 1) begin
         if (pushed >= nnum && $urandom_range(29) == 0) break;
         if (pushed < nnum && (depth < 2 || nnum > 30 || $urandom_range(1) == 0)) begin
            s = {s, num_text()};
            pushed++;
            depth++;
         end else begin
            s = {s, string'(ops[$urandom_range(3)])};
            depth--;
         end
         if (pushed < nnum || depth > 1) s = {s, ($urandom_range(9) == 0) ? "  " : " "};
      end
      if ($urandom_range(9) == 0) s = {s, " "};
      if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
      return s;
   endfunction

   task automatic test_numbers();
      send_expr("0");
      send_expr("9223372036854775807");
      send_expr("-9223372036854775808");
      send_expr("9223372036854775808");
      send_expr("-9223372036854775809");
      send_expr("+42");
      send_expr("12a");
      send_expr("1a99999999999999999999");
      send_expr("99999999999999999999x");
   endtask

   task automatic test_operators();
      send_expr("3 4 +");
      send_expr("3 10 -");
      send_expr("6 -7 *");
      send_expr("-7 2 /");
      send_expr("+5 -0 + 2 *");
      send_expr("9223372036854775807 1 +");
      send_expr("-9223372036854775808 1 -");
      send_expr("4611686018427387904 2 *");
      send_expr("-4611686018427387904 2 *");
      send_expr("-9223372036854775808 -1 /");
   endtask

   task automatic test_errors();
      string s;
      send_expr("+");
      send_expr("1 0 /");
      send_expr("1 2");
      send_expr(" ");
      send_expr("1 * 2 3 +");
      s = "";
      for (int i = 0; i < DEPTH + 1; i++) s = {s, "1 "};
      send_expr({s, "1"});
   endtask

   task automatic test_noise();
      string s;
      repeat (20) begin
         s = "";
         repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(255)))};
         send_expr(s);
      end
   endtask

   task automatic test_random();
      int n;
      n = 0;
      while (chars_sent < 1100) begin
         quiet = (n >= 15 && n < 30);
         send_expr(gen_expr());
         n++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      clear_calc();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_numbers();
      test_operators();
      test_errors();
      test_noise();
      test_random();
      req_push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d expressions in %0d characters, checked %0d results",
               exprs_sent, chars_sent, results_seen);
      if (failures == 0) $display("rpn_checked_integer_evaluator_tb OK");
      else $display("rpn_checked_integer_evaluator_tb NOT OK");
      $finish;
   end

   initial begin
      #50000000;
      $display("rpn_checked_integer_evaluator_tb NOT OK");
      $finish;
   end
endmodule

[filelist.f]
+incdir+src
src/rpn_pkg.sv
src/rpn_ram.sv
src/rpn_front.sv
src/rpn_queue.sv
src/rpn_back.sv
src/rpn_checked_integer_evaluator.sv
tb/sv/rpn_checked_integer_evaluator_tb.sv
